// File: hdl/ray_ground_point_classifier_top_macros.svh
// Assertion macros for the ray ground point classifier.
`ifndef RAY_GROUND_POINT_CLASSIFIER_TOP_MACROS_SVH
`define RAY_GROUND_POINT_CLASSIFIER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define RGPC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rgpc: same-cycle check failed");
`define RGPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rgpc: next-cycle check failed");
`else
`define RGPC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define RGPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: hdl/rgpc_pkg.sv
// Shared types, constants and helpers for the ray ground point classifier.
package rgpc_pkg;

    localparam int unsigned RAY_COUNT_DEFAULT = 4096;

    localparam int unsigned RAY_W     = 12;
    localparam int unsigned RADIUS_W  = 17;
    localparam int unsigned HEIGHT_W  = 16;
    localparam int unsigned INDEX_W   = 16;
    localparam int unsigned SENSOR_W  = 13;
    localparam int unsigned TAN_W     = 16;
    localparam int unsigned SPACING_W = 10;
    localparam int unsigned MINH_W    = 10;
    localparam int unsigned GAP_W     = 13;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam int unsigned S_TDATA_W = 64;
    localparam int unsigned M_TDATA_W = 16;

    localparam logic [SENSOR_W-1:0]  SENSOR_HEIGHT_RST = 13'd1700;
    localparam logic [TAN_W-1:0]     LOCAL_TAN_RST     = 16'd5734;
    localparam logic [TAN_W-1:0]     GENERAL_TAN_RST   = 16'd3435;
    localparam logic [SPACING_W-1:0] MIN_SPACING_RST   = 10'd10;
    localparam logic [MINH_W-1:0]    MIN_HEIGHT_RST    = 10'd50;
    localparam logic [GAP_W-1:0]     RECLASS_GAP_RST   = 13'd200;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SENSOR_HEIGHT = 3'd0,
        CFG_LOCAL_TAN     = 3'd1,
        CFG_GENERAL_TAN   = 3'd2,
        CFG_MIN_SPACING   = 3'd3,
        CFG_MIN_HEIGHT    = 3'd4,
        CFG_RECLASS_GAP   = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [SENSOR_W-1:0]  sensor_height_mm;
        logic [TAN_W-1:0]     local_slope_tangent;
        logic [TAN_W-1:0]     general_slope_tangent;
        logic [SPACING_W-1:0] min_spacing_mm;
        logic [MINH_W-1:0]    min_height_threshold_mm;
        logic [GAP_W-1:0]     reclass_gap_mm;
    } cfg_t;

    typedef struct packed {
        logic                       ground;
        logic signed [HEIGHT_W-1:0] height;
        logic [RADIUS_W-1:0]        radius;
    } hist_entry_t;

    // ray mod n by conditional subtraction of shifted n
    function automatic logic [RAY_W-1:0] ray_mod(input logic [RAY_W-1:0] ray,
                                                 input int unsigned n);
        logic [28:0] rem;
        logic [28:0] sub;
        rem = 29'(ray);
        for (int k = RAY_W - 1; k >= 0; k--)
        begin
            sub = 29'(n) << k;
            if (rem >= sub)
            begin
                rem = rem - sub;
            end
        end
        return rem[RAY_W-1:0];
    endfunction

endpackage

// File: hdl/rgpc_cfg_regs.sv
// Configuration register file of the ray ground point classifier.
module rgpc_cfg_regs
    import rgpc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_SENSOR_HEIGHT: cfg_next.sensor_height_mm        = cfg_data[SENSOR_W-1:0];
                CFG_LOCAL_TAN:     cfg_next.local_slope_tangent     = cfg_data[TAN_W-1:0];
                CFG_GENERAL_TAN:   cfg_next.general_slope_tangent   = cfg_data[TAN_W-1:0];
                CFG_MIN_SPACING:   cfg_next.min_spacing_mm          = cfg_data[SPACING_W-1:0];
                CFG_MIN_HEIGHT:    cfg_next.min_height_threshold_mm = cfg_data[MINH_W-1:0];
                CFG_RECLASS_GAP:   cfg_next.reclass_gap_mm          = cfg_data[GAP_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sensor_height_mm        <= SENSOR_HEIGHT_RST;
            cfg_reg.local_slope_tangent     <= LOCAL_TAN_RST;
            cfg_reg.general_slope_tangent   <= GENERAL_TAN_RST;
            cfg_reg.min_spacing_mm          <= MIN_SPACING_RST;
            cfg_reg.min_height_threshold_mm <= MIN_HEIGHT_RST;
            cfg_reg.reclass_gap_mm          <= RECLASS_GAP_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: hdl/rgpc_hist_mem.sv
// Per-ray history memory: one write port, one registered read port.
module rgpc_hist_mem
    import rgpc_pkg::*;
#(
    parameter int unsigned DEPTH = RAY_COUNT_DEFAULT,
    parameter int unsigned AW    = $clog2(DEPTH)
)
(
    input  logic        clk,
    input  logic        rd_en,
    input  logic [AW-1:0] rd_addr,
    output hist_entry_t rd_data,
    input  logic        wr_en,
    input  logic [AW-1:0] wr_addr,
    input  hist_entry_t wr_data
);

    hist_entry_t hist_mem [DEPTH];
    hist_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            hist_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= hist_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hdl/rgpc_pipe.sv
// Classification pipeline: history lookup with forwarding, slope tests, output register.
module rgpc_pipe
    import rgpc_pkg::*;
#(
    parameter int unsigned RAY_COUNT = RAY_COUNT_DEFAULT,
    parameter int unsigned AW        = $clog2(RAY_COUNT)
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cfg_t                 cfg,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    input  logic                 s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    output logic                 m_axis_tuser,
    output logic                 rd_en,
    output logic [AW-1:0]        rd_addr,
    input  hist_entry_t          rd_data,
    output logic                 wr_en,
    output logic [AW-1:0]        wr_addr,
    output hist_entry_t          wr_data
);

    `include "ray_ground_point_classifier_top_macros.svh"

    logic                       adv;
    logic [RAY_W-1:0]           in_ray;
    logic [AW-1:0]              in_addr;

    // stage 1: history read in flight
    logic                       s1_valid_reg;
    logic [AW-1:0]              s1_addr_reg;
    logic                       s1_first_reg;
    logic [RADIUS_W-1:0]        s1_radius_reg;
    logic signed [HEIGHT_W-1:0] s1_height_reg;
    logic [INDEX_W-1:0]         s1_index_reg;

    logic                       hit_s2;
    logic                       hit_wb;
    logic [RADIUS_W-1:0]        prev_r;
    logic signed [HEIGHT_W-1:0] prev_h;
    logic                       prev_g;
    logic                       fwd_g;
    logic signed [17:0]         delta_r;
    logic signed [34:0]         local_prod;
    logic [32:0]                general_prod;
    logic                       spacing_gt;
    logic                       reclass_gt;

    // stage 2: thresholds and band tests
    logic                       s2_valid_reg;
    logic [AW-1:0]              s2_addr_reg;
    logic [RADIUS_W-1:0]        s2_radius_reg;
    logic signed [HEIGHT_W-1:0] s2_height_reg;
    logic [INDEX_W-1:0]         s2_index_reg;
    logic signed [HEIGHT_W-1:0] s2_prev_h_reg;
    logic                       s2_prev_g_reg;
    logic                       s2_fwd_g_reg;
    logic signed [18:0]         s2_t_raw_reg;
    logic [RADIUS_W-1:0]        s2_g_reg;
    logic                       s2_spacing_gt_reg;
    logic                       s2_reclass_gt_reg;

    logic signed [18:0]         t_clamped;
    logic signed [18:0]         min_h;
    logic signed [20:0]         h;
    logic signed [20:0]         ph;
    logic signed [20:0]         tt;
    logic signed [20:0]         gl;
    logic signed [20:0]         gg;
    logic                       prev_g_eff;
    logic                       local_in;
    logic                       general_in;
    logic                       reclass_in;
    logic                       cur_g;

    // last written entry
    logic                       wb_valid_reg;
    logic [AW-1:0]              wb_addr_reg;
    hist_entry_t                wb_data_reg;

    // output register
    logic                       out_valid_reg;
    logic [INDEX_W-1:0]         out_index_reg;
    logic                       out_ground_reg;

    assign adv           = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;

    assign in_ray  = s_axis_tdata[11:0];
    assign in_addr = AW'(ray_mod(in_ray, RAY_COUNT));

    assign rd_en   = adv;
    assign rd_addr = in_addr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            wb_valid_reg  <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                s1_valid_reg  <= s_axis_tvalid;
                s2_valid_reg  <= s1_valid_reg;
                out_valid_reg <= s2_valid_reg;
            end
            if (wr_en)
            begin
                wb_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_addr_reg   <= in_addr;
            s1_first_reg  <= s_axis_tuser;
            s1_radius_reg <= s_axis_tdata[28:12];
            s1_height_reg <= s_axis_tdata[44:29];
            s1_index_reg  <= s_axis_tdata[60:45];
        end
    end

    assign hit_s2 = s2_valid_reg && (s2_addr_reg == s1_addr_reg);
    assign hit_wb = wb_valid_reg && (wb_addr_reg == s1_addr_reg);

    always_comb
    begin
        fwd_g = 1'b0;
        if (s1_first_reg)
        begin
            prev_r = '0;
            prev_h = -$signed(16'(cfg.sensor_height_mm));
            prev_g = 1'b0;
        end
        else if (hit_s2)
        begin
            // ground flag of the item ahead resolves one stage later
            prev_r = s2_radius_reg;
            prev_h = s2_height_reg;
            prev_g = 1'b0;
            fwd_g  = 1'b1;
        end
        else if (hit_wb)
        begin
            prev_r = wb_data_reg.radius;
            prev_h = wb_data_reg.height;
            prev_g = wb_data_reg.ground;
        end
        else
        begin
            prev_r = rd_data.radius;
            prev_h = rd_data.height;
            prev_g = rd_data.ground;
        end
    end

    assign delta_r      = $signed({1'b0, s1_radius_reg}) - $signed({1'b0, prev_r});
    assign local_prod   = $signed({1'b0, cfg.local_slope_tangent}) * delta_r;
    assign general_prod = cfg.general_slope_tangent * s1_radius_reg;
    assign spacing_gt   = delta_r > $signed(18'(cfg.min_spacing_mm));
    assign reclass_gt   = delta_r > $signed(18'(cfg.reclass_gap_mm));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_addr_reg       <= s1_addr_reg;
            s2_radius_reg     <= s1_radius_reg;
            s2_height_reg     <= s1_height_reg;
            s2_index_reg      <= s1_index_reg;
            s2_prev_h_reg     <= prev_h;
            s2_prev_g_reg     <= prev_g;
            s2_fwd_g_reg      <= fwd_g;
            s2_t_raw_reg      <= local_prod[34:16];
            s2_g_reg          <= general_prod[32:16];
            s2_spacing_gt_reg <= spacing_gt;
            s2_reclass_gt_reg <= reclass_gt;
        end
    end

    assign min_h     = $signed(19'(cfg.min_height_threshold_mm));
    assign t_clamped = (s2_spacing_gt_reg && (s2_t_raw_reg < min_h)) ? min_h : s2_t_raw_reg;

    assign h  = 21'(s2_height_reg);
    assign ph = 21'(s2_prev_h_reg);
    assign tt = 21'(t_clamped);
    assign gl = -$signed(21'(cfg.sensor_height_mm));
    assign gg = $signed(21'(s2_g_reg));

    assign prev_g_eff = s2_fwd_g_reg ? wb_data_reg.ground : s2_prev_g_reg;
    assign local_in   = (h <= ph + tt) && (h >= ph - tt);
    assign general_in = (h <= gl + gg) && (h >= gl - gg);
    assign reclass_in = (h <= gl + tt) && (h >= gl - tt);
    assign cur_g      = local_in ? (prev_g_eff || general_in)
                                 : (s2_reclass_gt_reg && reclass_in);

    assign wr_en          = s2_valid_reg && adv;
    assign wr_addr        = s2_addr_reg;
    assign wr_data.ground = cur_g;
    assign wr_data.height = s2_height_reg;
    assign wr_data.radius = s2_radius_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            wb_addr_reg <= s2_addr_reg;
            wb_data_reg <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && s2_valid_reg)
        begin
            out_index_reg  <= s2_index_reg;
            out_ground_reg <= cur_g;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_index_reg;
    assign m_axis_tuser  = out_ground_reg;

    `RGPC_ASSERT_IMPLY(a_stall_blocks_write, clk, rst_n, out_valid_reg && !m_axis_tready, !wr_en)
    `RGPC_ASSERT_IMPLY(a_fwd_from_last_write, clk, rst_n, s2_valid_reg && s2_fwd_g_reg, wb_valid_reg && (wb_addr_reg == s2_addr_reg))
    `RGPC_ASSERT_NEXT(a_write_lands_in_output, clk, rst_n, wr_en, out_valid_reg && (out_index_reg == $past(s2_index_reg)))

endmodule

// File: hdl/ray_ground_point_classifier_top.sv
// Top level of the ray ground point classifier.
//
//  port group     dir   beat contents
//  s_axis_*       in    one lidar point: ray, radius, height, index; tuser = first_in_ray
//  m_axis_*       out   one result: tdata = out_index, tuser = is_ground
//  cfg_*          in    register write, index 0..5, no read-back
//
// One beat per cycle each way unless the output stalls; a point passes stage 1, stage 2
// and the output register. History is read at accept, written in stage 2; a later point
// of the same ray takes the newer entry from the pipeline or the last-write register.
// Output stall freezes the whole pipeline; s_axis_tready drops only while a result waits.
// Reset clears control only: the memory is not cleared, so seed each ray with first_in_ray.
module ray_ground_point_classifier_top
    import rgpc_pkg::*;
#(
    parameter int unsigned RAY_COUNT = RAY_COUNT_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // ray_index[11:0], radius_mm[28:12], height_mm[44:29], point_index[60:45], zero[63:61]
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,
    // first_in_ray
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // out_index[15:0]
    output logic [M_TDATA_W-1:0]  m_axis_tdata,
    // is_ground
    output logic                  m_axis_tuser
);

    localparam int unsigned AW = $clog2(RAY_COUNT);

    cfg_t        cfg;
    logic        rd_en;
    logic [AW-1:0] rd_addr;
    hist_entry_t rd_data;
    logic        wr_en;
    logic [AW-1:0] wr_addr;
    hist_entry_t wr_data;

    rgpc_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rgpc_hist_mem #(
        .DEPTH (RAY_COUNT),
        .AW    (AW)
    ) u_mem
    (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    rgpc_pipe #(
        .RAY_COUNT (RAY_COUNT),
        .AW        (AW)
    ) u_pipe
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data)
    );

endmodule
